// ===== rtl/core/bp_pkg.sv =====
// ----------------------------------------------------------------------------
// Branch predictor package
// Shared types, register indexes, mode codes and reset values for the
// bimodal / gshare / pshare branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package bp_pkg;

    // Width of a branch address on the input channel.
    localparam int ADDR_W = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PREDICTOR_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_HISTORY_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_HISTORY_BITS = 2'd3;

    // Predictor modes; the unused code behaves as bimodal.
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_PSHARE  = 2'd2;

    // Register reset values.
    localparam logic [1:0] RST_PREDICTOR_MODE = MODE_BIMODAL;
    localparam logic [3:0] RST_INDEX_BITS     = 4'd12;
    localparam logic [4:0] RST_HISTORY_BITS   = 5'd8;

    // Two-bit saturating counter.
    typedef logic [1:0] t_ctr;
    localparam t_ctr CTR_MIN = 2'd0;
    localparam t_ctr CTR_MAX = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/bp_in_if.sv =====
// ----------------------------------------------------------------------------
// Branch input channel
// Carries one resolved branch per beat: its address and actual outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface bp_in_if import bp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] branch_address;
    logic              outcome_taken;

    modport source (output valid, output branch_address, output outcome_taken,
                    input ready);
    modport sink   (input valid, input branch_address, input outcome_taken,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/core/bp_out_if.sv =====
// ----------------------------------------------------------------------------
// Prediction result channel
// Carries one result per beat: the prediction and whether it was right.
// ----------------------------------------------------------------------------
`default_nettype none

interface bp_out_if;

    logic valid;
    logic ready;
    logic predicted_taken;
    logic prediction_correct;

    modport source (output valid, output predicted_taken, output prediction_correct,
                    input ready);
    modport sink   (input valid, input predicted_taken, input prediction_correct,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/core/bp_ram.sv =====
// ----------------------------------------------------------------------------
// Predictor table RAM
// Simple dual-port memory: one write port, one read port with registered
// read data. A read and a write to the same address return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 2
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [ADDR_BITS-1:0] i_waddr,
    input  wire [DATA_BITS-1:0] i_wdata,
    input  wire                 i_re,
    input  wire [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/branch_predictor_2bit_gshare_pshare.sv =====
// ----------------------------------------------------------------------------
// Bimodal / gshare / pshare branch predictor
// Indexes a table of two-bit saturating counters with the low branch address
// bits, optionally XORed with global or per-branch history, reports the
// prediction and its correctness, then trains the counter and histories.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Beat contents
//  i_branch   in         branch_address, outcome_taken
//  o_result   out        predicted_taken, prediction_correct
//  i_cfg_*    in         register index, write data (write only)
//
//  One branch beat is taken every cycle unless o_result stalls; its result is
//  offered after the history RAM read, the counter RAM read and the result
//  register. Same-slot updates from neighbouring beats are forwarded.
//  After reset both tables are cleared one entry per cycle, over all
//  2**MAX_INDEX_BITS entries, and no branch is taken during that pass.
//  A stall on o_result holds every stage; i_branch stays ready while one is free.
//
`default_nettype none

module branch_predictor_2bit_gshare_pshare import bp_pkg::*; #(
    parameter int MAX_INDEX_BITS   = 12,
    parameter int MAX_HISTORY_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    bp_in_if.sink                i_branch,
    bp_out_if.source             o_result,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = MAX_INDEX_BITS;
    localparam int HW = MAX_HISTORY_BITS;

    // Configuration registers.
    logic [1:0] r_mode;
    logic [3:0] r_index_bits;
    logic [4:0] r_ghist_bits;
    logic [4:0] r_phist_bits;

    // Clearing pass state.
    logic          r_clearing;
    logic [IW-1:0] r_clr_idx;

    // Stage 1: address and outcome, private history read in flight.
    logic              r_s1_v;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_taken;

    // Stage 2: counter index and outcome, counter read in flight.
    logic          r_s2_v;
    logic [IW-1:0] r_s2_idx;
    logic          r_s2_taken;

    // Result register.
    logic r_out_v;
    logic r_out_pred;
    logic r_out_corr;

    // Global history and forwarding registers.
    logic [HW-1:0] r_ghist;
    logic          r_pfwd_v;
    logic [IW-1:0] r_pfwd_slot;
    logic [HW-1:0] r_pfwd_val;
    logic          r_cfwd_v;
    logic [IW-1:0] r_cfwd_idx;
    t_ctr          r_cfwd_val;

    // Combinational signals.
    logic          out_free, s2_free, s2_adv, s1_adv, in_ready;
    logic [IW-1:0] w_imask;
    logic [HW-1:0] w_gmask, w_pmask;
    logic [IW-1:0] w_in_slot, w_slot, w_idx;
    logic [HW-1:0] w_phist_rd, w_phist, n_phist;
    logic [HW-1:0] w_hist;
    logic [ADDR_W-1:0] w_key;
    t_ctr          w_ctr_rd, w_ctr, n_ctr;
    logic          w_pred;

    // RAM port signals.
    logic          ph_we, ct_we;
    logic [IW-1:0] ph_waddr, ct_waddr;
    logic [HW-1:0] ph_wdata;
    t_ctr          ct_wdata;

    // Handshake: each stage moves when the one ahead is free or moving.
    assign out_free        = !r_out_v || o_result.ready;
    assign s2_adv          = r_s2_v && out_free;
    assign s2_free         = !r_s2_v || out_free;
    assign s1_adv          = r_s1_v && s2_free;
    assign in_ready        = !r_clearing && (!r_s1_v || s2_free);
    assign i_branch.ready  = in_ready;

    // Masks from the configured lengths; an index length of zero acts as one.
    always_comb begin
        for (int b = 0; b < IW; b++) begin
            w_imask[b] = (b < int'(r_index_bits)) || (b == 0);
        end
        for (int b = 0; b < HW; b++) begin
            w_gmask[b] = (b < int'(r_ghist_bits));
            w_pmask[b] = (b < int'(r_phist_bits));
        end
    end

    // Private history slot of the arriving branch.
    assign w_in_slot = i_branch.branch_address[IW-1:0] & w_imask;

    // Stage 1: private history with forwarding, then the counter index.
    always_comb begin
        w_slot  = r_s1_addr[IW-1:0] & w_imask;
        w_phist = (r_pfwd_v && (r_pfwd_slot == w_slot)) ? r_pfwd_val : w_phist_rd;
        n_phist = (w_phist << 1) | HW'(r_s1_taken);
        case (r_mode)
            MODE_GSHARE: w_hist = r_ghist & w_gmask;
            MODE_PSHARE: w_hist = w_phist & w_pmask;
            default:     w_hist = '0;
        endcase
        w_key = r_s1_addr ^ ADDR_W'(w_hist);
        w_idx = w_key[IW-1:0] & w_imask;
    end

    // Stage 2: counter with forwarding, prediction and saturating update.
    always_comb begin
        w_ctr  = (r_cfwd_v && (r_cfwd_idx == r_s2_idx)) ? r_cfwd_val : w_ctr_rd;
        w_pred = w_ctr[1];
        n_ctr  = w_ctr;
        if (r_s2_taken) begin
            if (w_ctr != CTR_MAX) n_ctr = w_ctr + 2'd1;
        end else begin
            if (w_ctr != CTR_MIN) n_ctr = w_ctr - 2'd1;
        end
    end

    // RAM write ports: the clearing pass or the training update.
    always_comb begin
        if (r_clearing) begin
            ph_we    = 1'b1;
            ph_waddr = r_clr_idx;
            ph_wdata = '0;
            ct_we    = 1'b1;
            ct_waddr = r_clr_idx;
            ct_wdata = CTR_MIN;
        end else begin
            ph_we    = s1_adv;
            ph_waddr = w_slot;
            ph_wdata = n_phist;
            ct_we    = s2_adv;
            ct_waddr = r_s2_idx;
            ct_wdata = n_ctr;
        end
    end

    // Private history table.
    bp_ram #(
        .ADDR_BITS (IW),
        .DATA_BITS (HW)
    ) u_phist_ram (
        .i_clk   (i_clk),
        .i_we    (ph_we),
        .i_waddr (ph_waddr),
        .i_wdata (ph_wdata),
        .i_re    (i_branch.valid && in_ready),
        .i_raddr (w_in_slot),
        .o_rdata (w_phist_rd)
    );

    // Counter table.
    bp_ram #(
        .ADDR_BITS (IW),
        .DATA_BITS ($bits(t_ctr))
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_re    (s1_adv),
        .i_raddr (w_idx),
        .o_rdata (w_ctr_rd)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= RST_PREDICTOR_MODE;
            r_index_bits <= RST_INDEX_BITS;
            r_ghist_bits <= RST_HISTORY_BITS;
            r_phist_bits <= RST_HISTORY_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PREDICTOR_MODE:       r_mode       <= i_cfg_data[1:0];
                CFG_INDEX_BITS:           r_index_bits <= i_cfg_data[3:0];
                CFG_GLOBAL_HISTORY_BITS:  r_ghist_bits <= i_cfg_data;
                CFG_PRIVATE_HISTORY_BITS: r_phist_bits <= i_cfg_data;
            endcase
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + IW'(1);
            if (r_clr_idx == '1) r_clearing <= 1'b0;
        end
    end

    // Pipeline valid bits, global history and forwarding valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_ghist  <= '0;
            r_pfwd_v <= 1'b0;
            r_cfwd_v <= 1'b0;
        end else begin
            if (in_ready) r_s1_v <= i_branch.valid;
            if (in_ready) r_pfwd_v <= s1_adv;
            if (s2_free) r_s2_v <= r_s1_v;
            if (s1_adv) r_cfwd_v <= s2_adv;
            if (out_free) r_out_v <= r_s2_v;
            if (s1_adv) r_ghist <= (r_ghist << 1) | HW'(r_s1_taken);
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_branch.valid && in_ready) begin
            r_s1_addr   <= i_branch.branch_address;
            r_s1_taken  <= i_branch.outcome_taken;
            r_pfwd_slot <= w_slot;
            r_pfwd_val  <= n_phist;
        end
        if (s1_adv) begin
            r_s2_idx   <= w_idx;
            r_s2_taken <= r_s1_taken;
            r_cfwd_idx <= r_s2_idx;
            r_cfwd_val <= n_ctr;
        end
        if (s2_adv) begin
            r_out_pred <= w_pred;
            r_out_corr <= (w_pred == r_s2_taken);
        end
    end

    assign o_result.valid              = r_out_v;
    assign o_result.predicted_taken    = r_out_pred;
    assign o_result.prediction_correct = r_out_corr;

    // A reset always starts a clearing pass.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> r_clearing)
        else $error("clearing pass did not start after reset");

    // No branch is in flight while the tables are being cleared.
    a_empty_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_v && !r_s2_v && !r_out_v && !in_ready))
        else $error("pipeline busy during clearing pass");

    // A branch leaving stage one always lands in stage two.
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_s2_v)
        else $error("branch lost between stage one and stage two");

    // A full pipeline behind a stalled result holds stage one.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s2_v && r_out_v && !o_result.ready) |=> (r_s1_v && r_s2_v))
        else $error("stage dropped during output stall");

endmodule

`default_nettype wire
